/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/mgsv_pkg.sv */
// ----------------------------------------------------------------------------
// mgsv_pkg
// Transaction types, input codes and constants of the microphone front end.
// ----------------------------------------------------------------------------
package mgsv_pkg;

  // Input transaction codes; the fourth code is unused and ignored.
  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_START  = 2'd2
  } kind_t;

  // Configuration register indexes.
  localparam logic REG_GAIN_SHIFT   = 1'b0;
  localparam logic REG_SKIP_SAMPLES = 1'b1;

  localparam logic [2:0]  GAIN_SHIFT_RESET   = 3'd3;
  localparam logic [15:0] SKIP_SAMPLES_RESET = 16'd1600;

  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

  // Meter levels of eight and below decay straight to zero.
  localparam logic [15:0] DECAY_FLOOR = 16'd8;

  // Bar scaling: floor(px * 46 / 55) as (px * 54832) >> 16, exact for px < 64.
  localparam int unsigned PX_PROD_W = 22;
  localparam logic [PX_PROD_W-1:0] PX_MUL = 22'd54832;
  localparam logic [5:0] PX_MAX = 6'd46;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] sample_in;
    logic               recording;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               store_sample;
    logic [5:0]         vu_pixels;
    logic               vu_valid;
  } out_item_t;

endpackage

/* sv/mgsv_stream_if.sv */
// ----------------------------------------------------------------------------
// mgsv_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface mgsv_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

/* sv/mic_gain_skip_vu_meter_unit.sv */
// ----------------------------------------------------------------------------
// mic_gain_skip_vu_meter_unit
// Microphone gain with saturation, recording start skip and peak VU meter.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle; input register, one stage of logic
// and the result register form a two-entry pipeline that stalls as a whole.
// Reset (rst, synchronous): pipeline empty, peak, meter and skip count zero,
// gain shift 3, skip setting 1600.
`include "assert_macros.svh"

module mic_gain_skip_vu_meter_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data,
  mgsv_stream_if.sink   in_ch,
  mgsv_stream_if.source out_ch
);

  import mgsv_pkg::*;

  // Map a meter level to bar pixels: eight steps per octave above 256, taken
  // from a 3-bit fraction below the leading one, scaled by 46/55 and clamped.
  function automatic logic [5:0] level_to_pixels(input logic [15:0] lvl);
    logic [2:0]           oct;
    logic [15:0]          shifted;
    logic [5:0]           px;
    logic [PX_PROD_W-1:0] prod;
    logic [5:0]           scaled;
    oct = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (lvl[8+i]) oct = 3'(i);
    end
    // The shift reaches twelve, so it needs four bits.
    shifted = lvl >> ({1'b0, oct} + 4'd5);
    px      = {oct, shifted[2:0]};
    prod    = PX_PROD_W'(px) * PX_MUL;
    scaled  = prod[PX_PROD_W-1:16];
    if (lvl[15:8] == 8'd0) begin
      level_to_pixels = 6'd0;
    end else if (scaled > PX_MAX) begin
      level_to_pixels = PX_MAX;
    end else begin
      level_to_pixels = scaled;
    end
  endfunction

  logic [2:0]  gain_shift;
  logic [15:0] skip_samples;

  logic        in_v;
  in_item_t    in_q;
  logic        out_v;
  out_item_t   out_q;
  logic        advance;

  logic [15:0] peak_hold, peak_hold_next;
  logic [15:0] meter_level, meter_level_next;
  logic [15:0] skip_left, skip_left_next;
  out_item_t   res_next;

  logic signed [22:0] gained;
  logic signed [15:0] sat;
  logic [15:0]        mag;
  logic [15:0]        decayed;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_shift   <= GAIN_SHIFT_RESET;
      skip_samples <= SKIP_SAMPLES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_SHIFT:   gain_shift   <= cfg_data[2:0];
        REG_SKIP_SAMPLES: skip_samples <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Handshake: the whole pipeline moves when the result register can take.
  assign advance     = in_v && (!out_v || out_ch.ready);
  assign in_ch.ready = !in_v || advance;
  assign out_ch.valid = out_v;
  assign out_ch.data  = out_q;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_ch.ready) begin
      in_v <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_q <= in_ch.data;
    end
  end

  // Gain and saturation: the value fits when bits 22..15 all agree.
  always_comb begin
    gained = {{7{in_q.sample_in[15]}}, in_q.sample_in} <<< gain_shift;
    if ((gained[22:15] == 8'h00) || (gained[22:15] == 8'hFF)) begin
      sat = gained[15:0];
    end else if (gained[22]) begin
      sat = SAMPLE_MIN;
    end else begin
      sat = SAMPLE_MAX;
    end
    // Negation wraps full-scale negative to 0x8000, which reads as 32768.
    mag = sat[15] ? (~sat + 16'd1) : sat;
  end

  // Meter decay by one eighth.
  assign decayed = (meter_level > DECAY_FLOOR) ?
                   (meter_level - {3'b000, meter_level[15:3]}) : 16'd0;

  // Per-transaction state update and result.
  always_comb begin
    peak_hold_next   = peak_hold;
    meter_level_next = meter_level;
    skip_left_next   = skip_left;
    res_next         = '0;
    case (in_q.kind)
      KIND_SAMPLE: begin
        res_next.sample_out = sat;
        if (mag > peak_hold) peak_hold_next = mag;
        if (in_q.recording) begin
          if (skip_left != 16'd0) begin
            skip_left_next = skip_left - 16'd1;
          end else begin
            res_next.store_sample = 1'b1;
          end
        end
      end
      KIND_TICK: begin
        peak_hold_next     = 16'd0;
        meter_level_next   = (peak_hold > decayed) ? peak_hold : decayed;
        res_next.vu_pixels = level_to_pixels(meter_level_next);
        res_next.vu_valid  = 1'b1;
      end
      KIND_START: begin
        skip_left_next = skip_samples;
      end
      default: ;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_hold   <= 16'd0;
      meter_level <= 16'd0;
      skip_left   <= 16'd0;
    end else if (advance) begin
      peak_hold   <= peak_hold_next;
      meter_level <= meter_level_next;
      skip_left   <= skip_left_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (advance) begin
      out_v <= 1'b1;
    end else if (out_ch.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= res_next;
    end
  end

  // Checks on the datapath and the skip counter.
  `ASSERT_IMPLIES(a_tick_clean, out_v && out_q.vu_valid,
                  out_q.sample_out == 16'sd0 && !out_q.store_sample)
  `ASSERT_IMPLIES(a_pixels_range, out_v, out_q.vu_pixels <= PX_MAX)
  `ASSERT_IMPLIES(a_peak_range, 1'b1, peak_hold <= 16'h8000)
  `ASSERT_NEXT(a_skip_count, advance && in_q.kind == KIND_SAMPLE && in_q.recording &&
               skip_left != 16'd0, skip_left == $past(skip_left) - 16'd1 && !out_q.store_sample)

endmodule

/* dv/tb_mic_gain_skip_vu_meter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mic_gain_skip_vu_meter_unit
// Self-checking bench for the microphone gain, recording skip and VU meter.
// A behavioural mirror of the gain stage, the peak hold, the meter decay and
// the skip counter works out each result as its input transaction is
// accepted. Results are compared field by field in arrival order. Directed
// corner cases come first, then random traffic under several register
// settings, with random idling on both the input and the output channel.
// ----------------------------------------------------------------------------
module tb_mic_gain_skip_vu_meter_unit;
  import mgsv_pkg::*;

  // The fourth input code has no meaning and must be ignored by the block.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int REPORT_MAX = 10;

  // Mirror of the front end: gain, peak hold, meter level and skip count.
  class mic_chain;
    logic [2:0]  gain_shift   = GAIN_SHIFT_RESET;
    logic [15:0] skip_samples = SKIP_SAMPLES_RESET;
    logic [15:0] peak_hold    = '0;
    logic [15:0] meter_level  = '0;
    logic [15:0] skip_left    = '0;
    out_item_t   queued_outputs[$];
    int          bad_fields   = 0;

    function void set_reg(logic idx, logic [15:0] value);
      if (idx == REG_GAIN_SHIFT) begin
        gain_shift = value[2:0];
      end else begin
        skip_samples = value;
      end
    endfunction

    // Eight pixels per octave above 256 with a three-bit fraction, scaled
    // by 46/55 and clamped to the bar width.
    function logic [5:0] bar_width(logic [15:0] level);
      int unsigned msb;
      int unsigned px;
      if (level < 16'd256) begin
        return '0;
      end
      msb = 8;
      while (msb < 15 && (level >> (msb + 1)) != 0) begin
        msb++;
      end
      px = (msb - 8) * 8 + ((level >> (msb - 3)) & 7);
      px = px * 46 / 55;
      if (px > 46) begin
        px = 46;
      end
      return px[5:0];
    endfunction

    function void take_input(in_item_t it);
      out_item_t          r;
      logic signed [31:0] wide;
      logic [15:0]        mag;
      logic [15:0]        decayed;
      r = '0;
      case (it.kind)
        KIND_SAMPLE: begin
          wide = it.sample_in;
          wide = wide <<< gain_shift;
          if (wide > 32767) begin
            wide = 32767;
          end else if (wide < -32768) begin
            wide = -32768;
          end
          r.sample_out = wide[15:0];
          mag = (wide < 0) ? 16'(-wide) : 16'(wide);
          if (mag > peak_hold) begin
            peak_hold = mag;
          end
          if (it.recording) begin
            if (skip_left != 0) begin
              skip_left--;
            end else begin
              r.store_sample = 1'b1;
            end
          end
        end
        KIND_TICK: begin
          decayed = (meter_level > DECAY_FLOOR) ? meter_level - (meter_level >> 3) : '0;
          meter_level = (peak_hold > decayed) ? peak_hold : decayed;
          peak_hold = '0;
          r.vu_pixels = bar_width(meter_level);
          r.vu_valid = 1'b1;
        end
        KIND_START: begin
          skip_left = skip_samples;
        end
        default: begin
        end
      endcase
      queued_outputs.push_back(r);
    endfunction

    function void flag(string what, int want, int got);
      bad_fields++;
      if (bad_fields <= REPORT_MAX) begin
        $display("mismatch in %s: expected %0d, got %0d", what, want, got);
      end
    endfunction

    function void check_output(out_item_t got);
      out_item_t want;
      if (queued_outputs.size() == 0) begin
        flag("unrequested result, sample_out", 0, int'(got.sample_out));
        return;
      end
      want = queued_outputs.pop_front();
      if (got.sample_out !== want.sample_out) begin
        flag("sample_out", int'(want.sample_out), int'(got.sample_out));
      end
      if (got.store_sample !== want.store_sample) begin
        flag("store_sample", want.store_sample, got.store_sample);
      end
      if (got.vu_pixels !== want.vu_pixels) begin
        flag("vu_pixels", want.vu_pixels, got.vu_pixels);
      end
      if (got.vu_valid !== want.vu_valid) begin
        flag("vu_valid", want.vu_valid, got.vu_valid);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  mgsv_stream_if #(.payload_t(in_item_t))  in_ch ();
  mgsv_stream_if #(.payload_t(out_item_t)) out_ch ();

  mic_gain_skip_vu_meter_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  mic_chain chain = new;
  bit       steady_source;
  bit       steady_sink;
  bit       rec_on;
  int       cycles;

  // 12 ns clock.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog on the total run length.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Mostly no pause, sometimes a short one, rarely a long one.
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Output back-pressure, changed on the falling edge.
  initial begin : out_ready_drive
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ch.ready = 1'b0;
        hold--;
      end else begin
        out_ch.ready = 1'b1;
        if (!steady_sink) hold = pause_len();
      end
    end
  end

  // Every result transaction is checked at the rising edge that accepts it.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      chain.check_output(out_ch.data);
    end
  end

  // Offers one transaction, waits until the block takes it, then may pause the input.
  task automatic push_item(input in_item_t it);
    int gap;
    in_ch.data = it;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    chain.take_input(it);
    @(negedge clk);
    gap = steady_source ? 0 : pause_len();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send(input logic [1:0] kind, input logic [15:0] smp, input logic rec);
    in_item_t it;
    it.kind = kind;
    it.sample_in = smp;
    it.recording = rec;
    push_item(it);
  endtask

  // Waits until every outstanding result has come out, plus a margin for
  // the two-stage pipeline.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (chain.queued_outputs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    chain.set_reg(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Upper bits of the gain write carry noise that the register must drop.
  task automatic set_config(input logic [2:0] gain, input logic [15:0] skip);
    drain();
    write_reg(REG_GAIN_SHIFT, {13'($urandom), gain});
    write_reg(REG_SKIP_SAMPLES, skip);
  endtask

  // Sample values: full range, near the saturation point of the gain,
  // extremes, and quiet levels around the bottom of the meter.
  function automatic logic [15:0] sample_value(input logic [2:0] gain);
    int span;
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($urandom);
      4, 5, 6, 7: begin
        span = 32768 >> gain;
        v = $urandom_range(0, span + 1);
        return $urandom_range(0, 1) ? 16'(-v) : 16'(v);
      end
      8: begin
        case ($urandom_range(0, 4))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return 16'hFFFF;
          3: return 16'h0001;
          default: return 16'h0000;
        endcase
      end
      default: begin
        v = $urandom_range(0, 600);
        return $urandom_range(0, 1) ? 16'(-v) : 16'(v);
      end
    endcase
  endfunction

  // Mostly samples inside a recording, with ticks, starts and the odd
  // unused code mixed in.
  function automatic in_item_t make_item(input logic [2:0] gain);
    in_item_t it;
    int       r;
    it.kind = KIND_SAMPLE;
    it.sample_in = 16'($urandom);
    it.recording = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 4) begin
      it.kind = KIND_START;
      rec_on = 1'b1;
    end else if (r < 6) begin
      it.kind = KIND_UNUSED;
    end else if (r < 16) begin
      it.kind = KIND_TICK;
    end else begin
      if (r < 18) rec_on = !rec_on;
      it.sample_in = sample_value(gain);
      it.recording = rec_on;
    end
    return it;
  endfunction

  task automatic run_phase(input logic [2:0] gain, input logic [15:0] skip, input int count);
    int       done;
    int       burst;
    in_item_t it;
    set_config(gain, skip);
    steady_source = ($urandom_range(0, 3) == 0);
    steady_sink = ($urandom_range(0, 3) == 0);
    rec_on = 1'b1;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 49) == 0) begin
        // A run of ticks lets the meter decay towards zero.
        burst = $urandom_range(5, 30);
        repeat (burst) send(KIND_TICK, 16'($urandom), 1'($urandom));
        done += burst;
      end else begin
        it = make_item(gain);
        push_item(it);
        if (it.kind != KIND_UNUSED) done++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_GAIN_SHIFT;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    steady_source = 1'b0;
    steady_sink = 1'b0;
    rec_on = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Reset settings: gain of eight, long skip after a start.
    send(KIND_TICK, 16'h0000, 1'b0);
    send(KIND_SAMPLE, 16'h0001, 1'b0);
    send(KIND_SAMPLE, SAMPLE_MAX, 1'b0);
    send(KIND_SAMPLE, SAMPLE_MIN, 1'b0);
    send(KIND_TICK, 16'h0000, 1'b0);
    send(KIND_TICK, 16'h0000, 1'b0);
    send(KIND_UNUSED, 16'h1234, 1'b1);
    send(KIND_START, 16'h0000, 1'b0);
    send(KIND_SAMPLE, 16'hFFFF, 1'b1);
    send(KIND_SAMPLE, 16'h0020, 1'b1);
    send(KIND_TICK, 16'h0000, 1'b1);

    // Unity gain, two samples skipped, then storage; none while not recording.
    set_config(3'd0, 16'd2);
    send(KIND_START, 16'h0000, 1'b1);
    send(KIND_SAMPLE, 16'h0100, 1'b1);
    send(KIND_SAMPLE, 16'hFF00, 1'b1);
    send(KIND_SAMPLE, SAMPLE_MAX, 1'b1);
    send(KIND_SAMPLE, SAMPLE_MIN, 1'b1);
    send(KIND_SAMPLE, 16'h0005, 1'b0);
    send(KIND_TICK, 16'h0000, 1'b0);

    // Largest gain with no skip: exact full scale and hard saturation.
    set_config(3'd7, 16'd0);
    send(KIND_START, 16'h0000, 1'b1);
    send(KIND_SAMPLE, 16'h0100, 1'b1);
    send(KIND_SAMPLE, 16'hFF00, 1'b1);
    send(KIND_SAMPLE, 16'hFEFF, 1'b1);
    send(KIND_TICK, 16'h0000, 1'b1);
    send(KIND_TICK, 16'h0000, 1'b1);
    send(KIND_UNUSED, 16'hFFFF, 1'b0);

    // Random traffic under a spread of settings, extremes included.
    run_phase(3'd3, 16'd5, 70);
    run_phase(3'd0, 16'd0, 70);
    run_phase(3'd7, 16'hFFFF, 60);
    run_phase(3'($urandom), 16'($urandom_range(0, 20)), 70);
    run_phase(3'd1, 16'd1, 60);
    run_phase(3'd5, 16'd40, 70);

    drain();
    repeat (10) @(posedge clk);
    if (chain.bad_fields == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* mic_gain_skip_vu_meter_unit.f */
+incdir+sv
sv/mgsv_pkg.sv
sv/mgsv_stream_if.sv
sv/mic_gain_skip_vu_meter_unit.sv
dv/tb_mic_gain_skip_vu_meter_unit.sv
